// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies; used by every module of the block.
package i2cm_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
   localparam int unsigned UNIT_W = 16;

   // input kind codes
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   // register byte addresses
   localparam logic [2:0] ADDR_UNIT_TICKS = 3'd0;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_REC_LOW,
      PH_REC_HIGH,
      PH_ST_A,
      PH_ST_B,
      PH_ST_C,
      PH_ST_D,
      PH_ST_E,
      PH_SP_A,
      PH_SP_B,
      PH_SP_C,
      PH_SP_D,
      PH_WR_LOW,
      PH_WR_DATA,
      PH_WR_HIGH,
      PH_WA_LOW,
      PH_WA_REL,
      PH_WA_HIGH,
      PH_WA_END,
      PH_RD_HIGH,
      PH_RD_LOW,
      PH_RA_LOW,
      PH_RA_DRV,
      PH_RA_HIGH,
      PH_RA_LOW2,
      PH_RA_REL
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] wr_byte;
      logic       ack_enable;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_byte;
      logic       ack_seen;
      logic       rejected;
   } rsp_type;

   // classified item as it sits in the queue
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] wr_byte;
      logic       ack_enable;
      logic       sda_in;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

// ===== hw/rtl/i2c_master_byte_engine_unit.sv =====
// I2C master byte engine, top level: register port, front end, queue and
// back end. Depends on i2cm_pkg, i2cm_front, i2cm_fifo, i2cm_back.
//
// Usage:
//   req_* carries one bus tick per transfer: the sampled SDA level plus an
//   optional command (start, stop, write byte, read byte). Every request
//   transfer yields exactly one rsp_* transfer with the SCL/SDA drive levels,
//   busy/done flags, last read byte, last ack and a reject flag for a command
//   that arrived while a sequence was running.
//   The APB port holds unit_ticks (byte address 0), ticks per delay unit;
//   0 acts as 1. Write it only while the engine is idle. pready is tied high.
// Path/throughput:
//   A request transfer reaches the response side through the queue, then the
//   result register. One transfer per cycle is sustained while rsp_stall is
//   low; the limit is the sequencer's single state update per tick.
// Reset (synchronous): queue and result register empty, engine idle with SCL
//   low and SDA released, unit_ticks = 1.
// Stall: rsp_stall holds the result register; the queue keeps taking
//   requests until it fills, then req_stall goes high.
module i2c_master_byte_engine_unit #(
   parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [15:0] unit_ticks_ff, unit_ticks_in;

   logic                      push;
   logic                      pop;
   i2cm_pkg::entry_type       push_entry;
   i2cm_pkg::entry_type       head;
   i2cm_pkg::fifo_status_type fifo_status;

   // register file: a single timing register
   always_comb begin
      unit_ticks_in = unit_ticks_ff;
      if (psel && penable && pwrite && paddr == i2cm_pkg::ADDR_UNIT_TICKS) begin
         unit_ticks_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= 16'd1;
      end else begin
         unit_ticks_ff <= unit_ticks_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == i2cm_pkg::ADDR_UNIT_TICKS) ? {16'd0, unit_ticks_ff} : 32'd0;

   // decode stage
   i2cm_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // decoupling queue
   i2cm_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   // bus sequencer and result register
   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .unit_ticks  (unit_ticks_ff),
      .fifo_status (fifo_status),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== hw/rtl/i2cm_front.sv =====
// Front end: accepts request transfers and decodes the kind field.
// Depends on i2cm_pkg.
module i2cm_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  i2cm_pkg::req_type        req_data,
   input  i2cm_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output i2cm_pkg::entry_type      push_entry
);

   i2cm_pkg::cmd_type cmd;

   always_comb begin
      unique case (req_data.kind)
         i2cm_pkg::KIND_START: cmd = i2cm_pkg::CMD_START;
         i2cm_pkg::KIND_STOP:  cmd = i2cm_pkg::CMD_STOP;
         i2cm_pkg::KIND_WRITE: cmd = i2cm_pkg::CMD_WRITE;
         i2cm_pkg::KIND_READ:  cmd = i2cm_pkg::CMD_READ;
         default:              cmd = i2cm_pkg::CMD_NONE; // tick only, unknown codes too
      endcase
   end

   assign req_stall = fifo_status.full;
   assign push      = req_valid && !fifo_status.full;

   assign push_entry.cmd        = cmd;
   assign push_entry.wr_byte    = req_data.wr_byte;
   assign push_entry.ack_enable = req_data.ack_enable;
   assign push_entry.sda_in     = req_data.sda_in;

endmodule

// ===== hw/rtl/i2cm_fifo.sv =====
// Short queue of decoded items between front and back end.
// Depends on i2cm_pkg.
module i2cm_fifo #(
   parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  i2cm_pkg::entry_type       push_entry,
   input  logic                      pop,
   output i2cm_pkg::entry_type       head,
   output i2cm_pkg::fifo_status_type status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   i2cm_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full && !pop |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/i2cm_back.sv =====
// Back end: bus sequencer that runs one queued item per cycle unless the queue is empty or
// the result register is stalled, plus the result register. Depends on i2cm_pkg.
module i2cm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               unit_ticks,
   input  i2cm_pkg::fifo_status_type fifo_status,
   input  i2cm_pkg::entry_type       head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output i2cm_pkg::rsp_type         rsp_data
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [15:0] unit_count_ff, unit_count_in;
   logic [1:0]  units_left_ff, units_left_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic [7:0]  read_ff, read_in;
   logic        slave_ack_ff, slave_ack_in;

   logic              rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   i2cm_pkg::phase_type nx;
   logic        is_cmd, enter, done, rej;
   logic [15:0] unit_len;
   logic [3:0]  bit_next;

   assign pop      = !fifo_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign is_cmd   = (head.cmd != i2cm_pkg::CMD_NONE);
   assign unit_len = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
   assign bit_next = bit_index_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      unit_count_in = unit_count_ff;
      units_left_in = units_left_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      read_in       = read_ff;
      slave_ack_in  = slave_ack_ff;
      nx            = i2cm_pkg::PH_IDLE;
      enter         = 1'b0;
      done          = 1'b0;
      rej           = 1'b0;

      if (pop) begin
         if (phase_ff != i2cm_pkg::PH_IDLE) begin
            rej = is_cmd;
            if (units_left_ff == 2'd0) begin
               // segment over: take its sample, pick the successor
               unique case (phase_ff)
                  i2cm_pkg::PH_REC_LOW:  nx = i2cm_pkg::PH_REC_HIGH;
                  i2cm_pkg::PH_REC_HIGH: nx = head.sda_in ? i2cm_pkg::PH_ST_A
                                                          : i2cm_pkg::PH_REC_LOW;
                  i2cm_pkg::PH_ST_A:     nx = i2cm_pkg::PH_ST_B;
                  i2cm_pkg::PH_ST_B:     nx = i2cm_pkg::PH_ST_C;
                  i2cm_pkg::PH_ST_C:     nx = i2cm_pkg::PH_ST_D;
                  i2cm_pkg::PH_ST_D:     nx = i2cm_pkg::PH_ST_E;
                  i2cm_pkg::PH_SP_A:     nx = i2cm_pkg::PH_SP_B;
                  i2cm_pkg::PH_SP_B:     nx = i2cm_pkg::PH_SP_C;
                  i2cm_pkg::PH_SP_C:     nx = i2cm_pkg::PH_SP_D;
                  i2cm_pkg::PH_WR_LOW:   nx = i2cm_pkg::PH_WR_DATA;
                  i2cm_pkg::PH_WR_DATA:  nx = i2cm_pkg::PH_WR_HIGH;
                  i2cm_pkg::PH_WR_HIGH: begin
                     bit_index_in = bit_next;
                     nx = (bit_next < 4'd8) ? i2cm_pkg::PH_WR_LOW : i2cm_pkg::PH_WA_LOW;
                  end
                  i2cm_pkg::PH_WA_LOW:   nx = i2cm_pkg::PH_WA_REL;
                  i2cm_pkg::PH_WA_REL:   nx = i2cm_pkg::PH_WA_HIGH;
                  i2cm_pkg::PH_WA_HIGH: begin
                     slave_ack_in = !head.sda_in;
                     nx = i2cm_pkg::PH_WA_END;
                  end
                  i2cm_pkg::PH_RD_HIGH: begin
                     shift_in = {shift_ff[6:0], head.sda_in};
                     nx = i2cm_pkg::PH_RD_LOW;
                  end
                  i2cm_pkg::PH_RD_LOW: begin
                     bit_index_in = bit_next;
                     nx = (bit_next < 4'd8) ? i2cm_pkg::PH_RD_HIGH : i2cm_pkg::PH_RA_LOW;
                  end
                  i2cm_pkg::PH_RA_LOW:   nx = i2cm_pkg::PH_RA_DRV;
                  i2cm_pkg::PH_RA_DRV:   nx = i2cm_pkg::PH_RA_HIGH;
                  i2cm_pkg::PH_RA_HIGH:  nx = i2cm_pkg::PH_RA_LOW2;
                  i2cm_pkg::PH_RA_LOW2:  nx = i2cm_pkg::PH_RA_REL;
                  i2cm_pkg::PH_RA_REL: begin
                     read_in = shift_ff;
                     nx = i2cm_pkg::PH_IDLE;
                  end
                  default:               nx = i2cm_pkg::PH_IDLE; // last edge of start, stop, write
               endcase
               if (nx == i2cm_pkg::PH_IDLE) begin
                  phase_in      = i2cm_pkg::PH_IDLE;
                  units_left_in = 2'd0;
                  unit_count_in = 16'd0;
                  done          = 1'b1;
               end else begin
                  enter = 1'b1;
               end
            end
         end else if (is_cmd) begin
            bit_index_in = 4'd0;
            enter        = 1'b1;
            unique case (head.cmd)
               i2cm_pkg::CMD_START: begin
                  nx = head.sda_in ? i2cm_pkg::PH_ST_A : i2cm_pkg::PH_REC_LOW;
               end
               i2cm_pkg::CMD_STOP: begin
                  nx = i2cm_pkg::PH_SP_A;
               end
               i2cm_pkg::CMD_WRITE: begin
                  shift_in = head.wr_byte;
                  nx = i2cm_pkg::PH_WR_LOW;
               end
               default: begin
                  shift_in      = 8'd0;
                  ack_choice_in = head.ack_enable;
                  nx = i2cm_pkg::PH_RD_HIGH;
               end
            endcase
         end

         if (enter) begin
            units_left_in = 2'd1;
            unique case (nx)
               i2cm_pkg::PH_REC_LOW: begin
                  scl_in = 1'b0; sda_in = 1'b0; units_left_in = 2'd3;
               end
               i2cm_pkg::PH_REC_HIGH: begin
                  scl_in = 1'b1; sda_in = 1'b1; units_left_in = 2'd3;
               end
               i2cm_pkg::PH_ST_A:    scl_in = 1'b0;
               i2cm_pkg::PH_ST_B:    sda_in = 1'b1;
               i2cm_pkg::PH_ST_C:    scl_in = 1'b1;
               i2cm_pkg::PH_ST_D:    sda_in = 1'b0;
               i2cm_pkg::PH_ST_E:    scl_in = 1'b0;
               i2cm_pkg::PH_SP_A:    scl_in = 1'b0;
               i2cm_pkg::PH_SP_B:    sda_in = 1'b0;
               i2cm_pkg::PH_SP_C:    scl_in = 1'b1;
               i2cm_pkg::PH_SP_D:    sda_in = 1'b1;
               i2cm_pkg::PH_WR_LOW:  scl_in = 1'b0;
               i2cm_pkg::PH_WR_DATA: begin
                  sda_in   = shift_in[7];
                  shift_in = {shift_in[6:0], 1'b0};
               end
               i2cm_pkg::PH_WR_HIGH: begin
                  scl_in = 1'b1; units_left_in = 2'd2;
               end
               i2cm_pkg::PH_WA_LOW:  scl_in = 1'b0;
               i2cm_pkg::PH_WA_REL:  sda_in = 1'b1;
               i2cm_pkg::PH_WA_HIGH: scl_in = 1'b1;
               i2cm_pkg::PH_WA_END:  scl_in = 1'b0;
               i2cm_pkg::PH_RD_HIGH: begin
                  scl_in = 1'b1; sda_in = 1'b1; // released while sampling
               end
               i2cm_pkg::PH_RD_LOW: begin
                  scl_in = 1'b0; units_left_in = 2'd2;
               end
               i2cm_pkg::PH_RA_LOW:  scl_in = 1'b0;
               i2cm_pkg::PH_RA_DRV:  sda_in = !ack_choice_in;
               i2cm_pkg::PH_RA_HIGH: begin
                  scl_in = 1'b1; units_left_in = 2'd2;
               end
               i2cm_pkg::PH_RA_LOW2: scl_in = 1'b0;
               i2cm_pkg::PH_RA_REL:  sda_in = 1'b1;
               default: ;
            endcase
            phase_in      = nx;
            unit_count_in = 16'd0;
         end

         // unit timer
         if (phase_in != i2cm_pkg::PH_IDLE) begin
            unit_count_in = unit_count_in + 16'd1;
            if (unit_count_in >= unit_len) begin
               unit_count_in = 16'd0;
               if (units_left_in != 2'd0) begin
                  units_left_in = units_left_in - 2'd1;
               end
            end
         end
      end

      rsp_data_in.scl_out  = scl_in;
      rsp_data_in.sda_out  = sda_in;
      rsp_data_in.busy_res = (phase_in != i2cm_pkg::PH_IDLE);
      rsp_data_in.done_res = done;
      rsp_data_in.rd_byte  = read_in;
      rsp_data_in.ack_seen = slave_ack_in;
      rsp_data_in.rejected = rej;

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cm_pkg::PH_IDLE;
         unit_count_ff <= '0;
         units_left_ff <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         ack_choice_ff <= 1'b0;
         scl_ff        <= 1'b0;
         sda_ff        <= 1'b1;
         read_ff       <= '0;
         slave_ack_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         unit_count_ff <= unit_count_in;
         units_left_ff <= units_left_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         ack_choice_ff <= ack_choice_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         read_ff       <= read_in;
         slave_ack_ff  <= slave_ack_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == i2cm_pkg::PH_IDLE |-> unit_count_ff == '0 && units_left_ff == '0)
      else $error("timer running while idle");

   a_bit_bound: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("bit index past byte end");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      pop && is_cmd && phase_ff != i2cm_pkg::PH_IDLE |=> rsp_data_ff.rejected)
      else $error("busy command not flagged");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      pop && done |=> !rsp_data_ff.busy_res && phase_ff == i2cm_pkg::PH_IDLE)
      else $error("done while still busy");

endmodule
